// ----- rtl/smx_pkg.sv -----
// shared opcodes, fault codes and stack effect tables for the stack machine executor
package smx_pkg;

  localparam logic [5:0] OP_HALT    = 6'd0;
  localparam logic [5:0] OP_PUSH    = 6'd1;
  localparam logic [5:0] OP_RVALUE  = 6'd2;
  localparam logic [5:0] OP_LVALUE  = 6'd3;
  localparam logic [5:0] OP_POP     = 6'd4;
  localparam logic [5:0] OP_STO     = 6'd5;
  localparam logic [5:0] OP_COPY    = 6'd6;
  localparam logic [5:0] OP_ADD     = 6'd7;
  localparam logic [5:0] OP_SUB     = 6'd8;
  localparam logic [5:0] OP_MPY     = 6'd9;
  localparam logic [5:0] OP_DIV     = 6'd10;
  localparam logic [5:0] OP_MOD     = 6'd11;
  localparam logic [5:0] OP_NEG     = 6'd12;
  localparam logic [5:0] OP_NOT     = 6'd13;
  localparam logic [5:0] OP_OR      = 6'd14;
  localparam logic [5:0] OP_AND     = 6'd15;
  localparam logic [5:0] OP_EQ      = 6'd16;
  localparam logic [5:0] OP_NE      = 6'd17;
  localparam logic [5:0] OP_GT      = 6'd18;
  localparam logic [5:0] OP_GE      = 6'd19;
  localparam logic [5:0] OP_LT      = 6'd20;
  localparam logic [5:0] OP_LE      = 6'd21;
  localparam logic [5:0] OP_LABEL   = 6'd22;
  localparam logic [5:0] OP_GOTO    = 6'd23;
  localparam logic [5:0] OP_GOFALSE = 6'd24;
  localparam logic [5:0] OP_GOTRUE  = 6'd25;
  localparam logic [5:0] OP_PRINT   = 6'd26;
  localparam logic [5:0] OP_READ    = 6'd27;
  localparam logic [5:0] OP_GOSUB   = 6'd28;
  localparam logic [5:0] OP_RET     = 6'd29;
  localparam logic [5:0] OP_ORB     = 6'd30;
  localparam logic [5:0] OP_ANDB    = 6'd31;
  localparam logic [5:0] OP_XORB    = 6'd32;
  localparam logic [5:0] OP_SHL     = 6'd33;
  localparam logic [5:0] OP_SHR     = 6'd34;
  localparam logic [5:0] OP_SAR     = 6'd35;
  localparam logic [5:0] OP_COUNT   = 6'd36;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_UNDER = 3'd1;
  localparam logic [2:0] FLT_OVER  = 3'd2;
  localparam logic [2:0] FLT_DIVZ  = 3'd3;
  localparam logic [2:0] FLT_ILL   = 3'd4;

  function automatic logic [1:0] pops_of(input logic [5:0] op);
    case (op)
      OP_STO, OP_ADD, OP_SUB, OP_MPY, OP_DIV, OP_MOD, OP_OR, OP_AND,
      OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE, OP_ORB, OP_ANDB, OP_XORB:
        pops_of = 2'd2;
      OP_POP, OP_COPY, OP_NEG, OP_NOT, OP_GOFALSE, OP_GOTRUE, OP_PRINT,
      OP_SHL, OP_SHR, OP_SAR:
        pops_of = 2'd1;
      default: pops_of = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pushes_of(input logic [5:0] op);
    case (op)
      OP_COPY: pushes_of = 2'd2;
      OP_PUSH, OP_RVALUE, OP_LVALUE, OP_ADD, OP_SUB, OP_MPY, OP_DIV, OP_MOD,
      OP_NEG, OP_NOT, OP_OR, OP_AND, OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE,
      OP_READ, OP_ORB, OP_ANDB, OP_XORB, OP_SHL, OP_SHR, OP_SAR:
        pushes_of = 2'd1;
      default: pushes_of = 2'd0;
    endcase
  endfunction

endpackage

// ----- rtl/stack_machine_executor.sv -----
// stack machine executor: one instruction word in, one status word out
//
// input channel: in_valid/in_stall carries command, operand and read value.
// result channel: out_valid/out_stall carries next pc, print value, halt flag
// and fault code, one result word per instruction word.
// the block works on one instruction at a time. the accept edge reads the
// operand stack, call stack and data memory (synchronous read); in S_EXEC
// it computes and writes back once the output register is free. div and
// mod first run a bit serial divider through S_DIV and S_DFIN.
// the output register holds a finished result while the receiver stalls; the
// next instruction is still accepted and waits at write back until it frees.
// after reset the data memory is cleared one entry a cycle, all DATA_DEPTH
// entries, with in_stall high. stack tops, pc and the halt flag reset to zero.
// once halted every further word returns the same pc with halted set.
// PROGRAM_DEPTH must be a power of two; the block itself does not enforce it.
module stack_machine_executor #(
  parameter int STACK_DEPTH   = 256,
  parameter int CALL_DEPTH    = 64,
  parameter int DATA_DEPTH    = 32768,
  parameter int PROGRAM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_command,
  input  logic [14:0] in_operand,
  input  logic [31:0] in_read_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_next_pc,
  output logic        out_print_valid,
  output logic [31:0] out_print_value,
  output logic        out_halted,
  output logic [2:0]  out_fault
);

  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int TW  = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(CALL_DEPTH);
  localparam int RTW = $clog2(CALL_DEPTH + 1);
  localparam int DW  = $clog2(DATA_DEPTH);
  localparam int PW  = $clog2(PROGRAM_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DFIN} state_t;

  state_t          state_r;
  logic [TW-1:0]   top_r;
  logic [RTW-1:0]  rtop_r;
  logic [PW-1:0]   pc_r;
  logic            stopped_r;
  logic            clr_busy_r;
  logic [DW-1:0]   clr_r;

  logic [5:0]      cmd_r;
  logic [14:0]     opd_r;
  logic [31:0]     rdv_r;
  logic [31:0]     vb_r, va_r, ds_q_r;
  logic [15:0]     rs_q_r;
  logic            ds_ok_r;

  logic [31:0]     rem_r, quo_r;
  logic [4:0]      dcnt_r;

  logic            out_valid_r, out_pv_r, out_halt_r;
  logic [15:0]     out_pc_r;
  logic [31:0]     out_pval_r;
  logic [2:0]      out_fault_r;

  logic [31:0]     vs_mem [STACK_DEPTH];
  logic [15:0]     rs_mem [CALL_DEPTH];
  logic [31:0]     ds_mem [DATA_DEPTH];

  logic            acc, out_free, commit, ok, is_div;
  logic [1:0]      pops, pushes;
  logic [TW:0]     lvl;
  logic [2:0]      fault_c;
  logic [31:0]     ds_q, r_c;
  logic [PW-1:0]   next_c, pc_inc, tgt;
  logic            pv_c;
  logic            vs_we, rs_we, ds_we;
  logic [SW-1:0]   vs_wa;
  logic [DW-1:0]   ds_wa;
  logic [31:0]     ds_wd;
  logic [32:0]     rem_sh;
  logic            rem_ge;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || clr_busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign ds_q     = ds_ok_r ? ds_q_r : 32'd0;
  assign pops     = smx_pkg::pops_of(cmd_r);
  assign pushes   = smx_pkg::pushes_of(cmd_r);
  assign lvl      = {1'b0, top_r} - (TW+1)'(pops) + (TW+1)'(pushes);
  assign is_div   = (cmd_r == smx_pkg::OP_DIV) || (cmd_r == smx_pkg::OP_MOD);
  assign pc_inc   = pc_r + 1'b1;
  assign tgt      = ds_q[PW-1:0] + 1'b1;

  always_comb begin
    if (stopped_r) begin
      fault_c = smx_pkg::FLT_NONE;
    end else if (cmd_r >= smx_pkg::OP_COUNT) begin
      fault_c = smx_pkg::FLT_ILL;
    end else if (top_r < TW'(pops)) begin
      fault_c = smx_pkg::FLT_UNDER;
    end else if (lvl > (TW+1)'(STACK_DEPTH)) begin
      fault_c = smx_pkg::FLT_OVER;
    end else if (cmd_r == smx_pkg::OP_RET && rtop_r == '0) begin
      fault_c = smx_pkg::FLT_UNDER;
    end else if (cmd_r == smx_pkg::OP_GOSUB && rtop_r >= RTW'(CALL_DEPTH)) begin
      fault_c = smx_pkg::FLT_OVER;
    end else if (is_div && vb_r == 32'd0) begin
      fault_c = smx_pkg::FLT_DIVZ;
    end else begin
      fault_c = smx_pkg::FLT_NONE;
    end
  end

  assign ok = !stopped_r && (fault_c == smx_pkg::FLT_NONE);

  always_comb begin
    r_c    = 32'd0;
    next_c = pc_inc;
    pv_c   = 1'b0;
    if (stopped_r) next_c = pc_r;
    else if (ok) begin
      case (cmd_r)
        smx_pkg::OP_HALT:    next_c = pc_r;
        smx_pkg::OP_PUSH,
        smx_pkg::OP_LVALUE:  r_c = 32'(opd_r);
        smx_pkg::OP_RVALUE:  r_c = ds_q;
        smx_pkg::OP_COPY:    r_c = vb_r;
        smx_pkg::OP_ADD:     r_c = va_r + vb_r;
        smx_pkg::OP_SUB:     r_c = va_r - vb_r;
        smx_pkg::OP_MPY:     r_c = va_r * vb_r;
        smx_pkg::OP_DIV:     r_c = quo_r;
        smx_pkg::OP_MOD:     r_c = rem_r;
        smx_pkg::OP_NEG:     r_c = 32'd0 - vb_r;
        smx_pkg::OP_NOT:     r_c = ~vb_r;
        smx_pkg::OP_OR:      r_c = 32'((va_r != 0) || (vb_r != 0));
        smx_pkg::OP_AND:     r_c = 32'((va_r != 0) && (vb_r != 0));
        smx_pkg::OP_EQ:      r_c = 32'(va_r == vb_r);
        smx_pkg::OP_NE:      r_c = 32'(va_r != vb_r);
        smx_pkg::OP_GT:      r_c = 32'(va_r > vb_r);
        smx_pkg::OP_GE:      r_c = 32'(va_r >= vb_r);
        smx_pkg::OP_LT:      r_c = 32'(va_r < vb_r);
        smx_pkg::OP_LE:      r_c = 32'(va_r <= vb_r);
        smx_pkg::OP_GOTO,
        smx_pkg::OP_GOSUB:   next_c = tgt;
        smx_pkg::OP_GOFALSE: if (vb_r == 32'd0) next_c = tgt;
        smx_pkg::OP_GOTRUE:  if (vb_r != 32'd0) next_c = tgt;
        smx_pkg::OP_PRINT:   pv_c = 1'b1;
        smx_pkg::OP_READ:    r_c = rdv_r;
        smx_pkg::OP_RET:     next_c = rs_q_r[PW-1:0] + 1'b1;
        smx_pkg::OP_ORB:     r_c = va_r | vb_r;
        smx_pkg::OP_ANDB:    r_c = va_r & vb_r;
        smx_pkg::OP_XORB:    r_c = va_r ^ vb_r;
        smx_pkg::OP_SHL:     r_c = {vb_r[30:0], 1'b0};
        smx_pkg::OP_SHR:     r_c = {1'b0, vb_r[31:1]};
        smx_pkg::OP_SAR:     r_c = {vb_r[31], vb_r[31:1]};
        default:             r_c = 32'd0;
      endcase
    end
  end

  assign commit = out_free &&
                  ((state_r == S_EXEC && !(ok && is_div)) || state_r == S_DFIN);

  assign vs_we = commit && ok && (pushes != 2'd0);
  assign vs_wa = SW'(lvl - 1'b1);
  assign rs_we = commit && ok && (cmd_r == smx_pkg::OP_GOSUB);

  always_comb begin
    ds_we = 1'b0;
    ds_wa = clr_r;
    ds_wd = 32'd0;
    if (clr_busy_r) ds_we = 1'b1;
    else if (commit && ok && cmd_r == smx_pkg::OP_STO) begin
      ds_we = va_r < 32'(DATA_DEPTH);
      ds_wa = va_r[DW-1:0];
      ds_wd = vb_r;
    end else if (commit && ok && cmd_r == smx_pkg::OP_LABEL) begin
      ds_we = {1'b0, opd_r} < 16'(DATA_DEPTH);
      ds_wa = opd_r[DW-1:0];
      ds_wd = 32'(pc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[vs_wa] <= r_c;
    if (acc) begin
      vb_r <= vs_mem[SW'(top_r - 1'b1)];
      va_r <= vs_mem[SW'(top_r - 2'd2)];
    end
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rtop_r[CW-1:0]] <= 16'(pc_r);
    if (acc) rs_q_r <= rs_mem[CW'(rtop_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (ds_we) ds_mem[ds_wa] <= ds_wd;
    if (acc) begin
      ds_q_r  <= ds_mem[in_operand[DW-1:0]];
      ds_ok_r <= {1'b0, in_operand} < 16'(DATA_DEPTH);
    end
  end

  assign rem_sh = {rem_r, quo_r[31]};
  assign rem_ge = rem_sh >= {1'b0, vb_r};

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_command;
      opd_r <= in_operand;
      rdv_r <= in_read_value;
    end
    if (state_r == S_EXEC) begin
      rem_r  <= 32'd0;
      quo_r  <= va_r;
      dcnt_r <= 5'd0;
    end else if (state_r == S_DIV) begin
      rem_r  <= rem_ge ? 32'(rem_sh - {1'b0, vb_r}) : rem_sh[31:0];
      quo_r  <= {quo_r[30:0], rem_ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (commit) begin
      out_pc_r    <= 16'(next_c);
      out_pv_r    <= pv_c;
      out_pval_r  <= pv_c ? vb_r : 32'd0;
      out_halt_r  <= stopped_r || (ok && cmd_r == smx_pkg::OP_HALT);
      out_fault_r <= fault_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      rtop_r      <= '0;
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == DW'(DATA_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      if (commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc) state_r <= S_EXEC;
        S_EXEC: begin
          if (ok && is_div) state_r <= S_DIV;
          else if (out_free) state_r <= S_IDLE;
        end
        S_DIV:  if (dcnt_r == 5'd31) state_r <= S_DFIN;
        S_DFIN: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (commit) begin
        pc_r <= next_c;
        if (ok) begin
          top_r <= TW'(lvl);
          if (cmd_r == smx_pkg::OP_HALT) stopped_r <= 1'b1;
          if (cmd_r == smx_pkg::OP_GOSUB) rtop_r <= rtop_r + 1'b1;
          if (cmd_r == smx_pkg::OP_RET) rtop_r <= rtop_r - 1'b1;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_print_valid = out_pv_r;
  assign out_print_value = out_pval_r;
  assign out_halted      = out_halt_r;
  assign out_fault       = out_fault_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r) else $error("halt flag cleared");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(STACK_DEPTH)) else $error("operand stack beyond depth");

  a_div_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> is_div) else $error("divider run for other op");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !acc) else $error("word taken during memory clear");

  a_print_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r != smx_pkg::FLT_NONE) |-> !out_pv_r)
    else $error("print on faulted word");

endmodule
